[rtl/lfpl_pkg.sv]
package lfpl_pkg;

    localparam int MAX_BULBS_DEF = 64;
    localparam int BYTE_W        = 8;
    localparam int WORD_W        = 32;
    localparam int Q_SHIFT       = 8;
    localparam int RATIO_W       = 9;
    localparam int WEIGHT_W      = 10;
    localparam int TINT_W        = 27;
    localparam int LOAD_W        = 18;
    localparam int CHAN_W        = 2;
    localparam int LANES         = 6;
    localparam int QUOT_STEPS    = 8;
    localparam int BULB_IDX_W    = 6;
    localparam int PADDR_W       = 5;
    localparam int PDATA_W       = 32;
    localparam int SUM_W         = 11;

    localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;
    localparam logic [CHAN_W-1:0] CHAN_RGB = 2'd3;

    localparam logic [RATIO_W-1:0]  RST_COOL_RATIO   = 9'd256;
    localparam logic [RATIO_W-1:0]  RST_WARM_RATIO   = 9'd256;
    localparam logic [WEIGHT_W-1:0] RST_WHITE_GAIN   = 10'd256;
    localparam logic [TINT_W-1:0]   RST_COOL_TINT    = 27'd0;
    localparam logic [LOAD_W-1:0]   RST_POWER_BUDGET = 18'd262143;
    localparam logic [CHAN_W-1:0]   RST_WARM_CHANNEL = 2'd0;
    localparam logic [CHAN_W-1:0]   RST_COOL_CHANNEL = 2'd3;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SUM,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        REG_COOL_RATIO,
        REG_WARM_RATIO,
        REG_WHITE_GAIN,
        REG_COOL_TINT,
        REG_POWER_BUDGET,
        REG_WARM_CHANNEL,
        REG_COOL_CHANNEL
    } t_reg;

    typedef struct packed {
        logic [RATIO_W-1:0]  cool_ratio;
        logic [RATIO_W-1:0]  warm_ratio;
        logic [WEIGHT_W-1:0] white_gain;
        logic [TINT_W-1:0]   cool_tint;
        logic [LOAD_W-1:0]   power_budget;
        logic [CHAN_W-1:0]   warm_channel;
        logic [CHAN_W-1:0]   cool_channel;
    } t_cfg;

    // Lanes 0..2 are red, green, blue; lanes 3..5 are white channels 0..2.
    typedef logic [LANES-1:0][BYTE_W-1:0] t_pixel;

    typedef struct packed {
        logic start;
        logic take;
    } t_div_ctl;

    function automatic logic [BYTE_W-1:0] sat8(input logic [SUM_W-1:0] v);
        logic [BYTE_W-1:0] r;
        r = (v > SUM_W'(BYTE_MAX)) ? BYTE_MAX : v[BYTE_W-1:0];
        return r;
    endfunction

endpackage

[rtl/lfpl_resolve.sv]
module lfpl_resolve (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [lfpl_pkg::WORD_W-1:0]   i_word,
    input  lfpl_pkg::t_cfg                i_cfg,
    output logic                          o_valid,
    output lfpl_pkg::t_pixel              o_px
);

    localparam int BYTE_W  = lfpl_pkg::BYTE_W;
    localparam int RATIO_W = lfpl_pkg::RATIO_W;
    localparam int PROD_W  = BYTE_W + RATIO_W;
    localparam int TPROD_W = 2 * RATIO_W;
    localparam int SUM_W   = lfpl_pkg::SUM_W;
    localparam int Q_SHIFT = lfpl_pkg::Q_SHIFT;
    localparam int CHAN_W  = lfpl_pkg::CHAN_W;

    logic                        r_v1;
    logic [2:0][BYTE_W-1:0]      r_rgb;
    logic [RATIO_W-1:0]          r_cool;
    logic [RATIO_W-1:0]          r_warm;
    logic [PROD_W-1:0]           n_cool_prod;
    logic [PROD_W-1:0]           n_warm_prod;
    logic                        r_v2;
    lfpl_pkg::t_pixel            r_px;
    lfpl_pkg::t_pixel            n_px;

    // First stage: split the white level into cool and warm parts.
    always_comb begin
        n_cool_prod = PROD_W'(i_word[31:24]) * PROD_W'(i_cfg.cool_ratio);
        n_warm_prod = PROD_W'(i_word[31:24]) * PROD_W'(i_cfg.warm_ratio);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_rgb  <= i_word[23:0];
        r_cool <= n_cool_prod[PROD_W-1:Q_SHIFT];
        r_warm <= n_warm_prod[PROD_W-1:Q_SHIFT];
    end

    // Second stage: route white parts and, when the cool part goes to RGB, tint the RGB bytes.
    always_comb begin
        logic [TPROD_W-1:0] tprod;
        logic [SUM_W-1:0]   tsum;
        n_px = '0;
        for (int c = 0; c < 3; c++) begin
            tprod = TPROD_W'(r_cool) * TPROD_W'(i_cfg.cool_tint[RATIO_W*c +: RATIO_W]);
            tsum  = SUM_W'(r_rgb[c]) + SUM_W'(tprod[TPROD_W-1:Q_SHIFT]);
            if (i_cfg.cool_channel == lfpl_pkg::CHAN_RGB) begin
                n_px[c] = lfpl_pkg::sat8(tsum);
            end else begin
                n_px[c] = r_rgb[c];
            end
        end
        for (int k = 0; k < 3; k++) begin
            if (i_cfg.warm_channel == CHAN_W'(k)) begin
                n_px[3+k] = lfpl_pkg::sat8(SUM_W'(r_warm));
            end
            // The cool byte wins when both parts land on one channel.
            if (i_cfg.cool_channel == CHAN_W'(k)) begin
                n_px[3+k] = lfpl_pkg::sat8(SUM_W'(r_cool));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_px <= n_px;
    end

    assign o_valid = r_v2;
    assign o_px    = r_px;

endmodule

[rtl/lfpl_divider.sv]
module lfpl_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lfpl_pkg::t_div_ctl            i_ctl,
    input  lfpl_pkg::t_pixel              i_px,
    input  logic [lfpl_pkg::LOAD_W-1:0]   i_num,
    input  logic [lfpl_pkg::LOAD_W-1:0]   i_den,
    output logic                          o_done,
    output lfpl_pkg::t_pixel              o_quot
);

    localparam int LANES  = lfpl_pkg::LANES;
    localparam int LOAD_W = lfpl_pkg::LOAD_W;
    localparam int BYTE_W = lfpl_pkg::BYTE_W;
    localparam int NUM_W  = LOAD_W + BYTE_W;
    localparam int STEPS  = lfpl_pkg::QUOT_STEPS;
    localparam int STEP_W = $clog2(STEPS);

    logic [LANES-1:0][LOAD_W-1:0] r_rem;
    lfpl_pkg::t_pixel             r_q;
    logic [LOAD_W-1:0]            r_den;
    logic [STEP_W-1:0]            r_step;
    logic                         r_busy;
    logic                         r_done;
    logic [LANES-1:0][NUM_W-1:0]  n_prod;
    logic [LANES-1:0][LOAD_W-1:0] n_rem;
    lfpl_pkg::t_pixel             n_q;

    // The quotient is known to fit a byte, so the top of the dividend is
    // already a valid partial remainder and only eight steps remain.
    always_comb begin
        logic [LOAD_W:0] t;
        logic            ge;
        for (int k = 0; k < LANES; k++) begin
            n_prod[k] = NUM_W'(i_px[k]) * NUM_W'(i_num) + NUM_W'(i_den >> 1);
            t  = {r_rem[k], r_q[k][BYTE_W-1]};
            ge = (t >= {1'b0, r_den});
            n_rem[k] = ge ? LOAD_W'(t - {1'b0, r_den}) : t[LOAD_W-1:0];
            n_q[k]   = {r_q[k][BYTE_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + STEP_W'(1);
            if (r_step == STEP_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else if (i_ctl.take) begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_den <= i_den;
            for (int k = 0; k < LANES; k++) begin
                r_rem[k] <= n_prod[k][NUM_W-1:BYTE_W];
                r_q[k]   <= n_prod[k][BYTE_W-1:0];
            end
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[rtl/led_frame_power_limiter.sv]
// Power-limited mapper from a frame of bulbs to driver pixels.
// Input channel (i_valid / o_stall): one bulb word per accepted cycle, each
// written to the bulb store; i_frame_end marks the last bulb of a frame.
// Bulbs beyond MAX_BULBS are dropped, but a dropped word still ends a frame.
// After the frame end the input stalls while the block makes one pass over
// the store to measure the frame load, then emits one result word per bulb
// on the output channel (o_valid / i_stall), in load order, with the last
// one flagged by o_final_bulb. On the emit pass each bulb goes through a
// store read, two resolve stages, the scale multiply and eight quotient
// steps of the six-lane divider, then the output register; the next bulb
// is read only after the divider has handed on the last one.
// When the receiver stalls, the result waits in the output register and
// the next bulb waits in the divider. Loading of the next frame may begin
// as soon as the last result has entered the output register.
// Reset clears the bulb count, the frame load and the configuration
// registers to their defaults; the store contents are left as they are.
// The configuration port is APB style, one register per word address.
module led_frame_power_limiter #(
    parameter int MAX_BULBS = lfpl_pkg::MAX_BULBS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lfpl_pkg::PADDR_W-1:0]   paddr,
    input  logic [lfpl_pkg::PDATA_W-1:0]   pwdata,
    output logic [lfpl_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_red_level,
    input  logic [7:0]                     i_green_level,
    input  logic [7:0]                     i_blue_level,
    input  logic [7:0]                     i_white_level,
    input  logic                           i_frame_end,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [5:0]                     o_bulb_index,
    output logic [7:0]                     o_color_red,
    output logic [7:0]                     o_color_green,
    output logic [7:0]                     o_color_blue,
    output logic [7:0]                     o_white_first,
    output logic [7:0]                     o_white_second,
    output logic [7:0]                     o_white_third,
    output logic                           o_over_budget,
    output logic [17:0]                    o_total_load,
    output logic                           o_final_bulb
);

    localparam int IDX_W    = (MAX_BULBS > 1) ? $clog2(MAX_BULBS) : 1;
    localparam int CNT_W    = $clog2(MAX_BULBS + 1);
    localparam int WORD_W   = lfpl_pkg::WORD_W;
    localparam int LOAD_W   = lfpl_pkg::LOAD_W;
    localparam int WEIGHT_W = lfpl_pkg::WEIGHT_W;
    localparam int Q_SHIFT  = lfpl_pkg::Q_SHIFT;
    localparam int PDATA_W  = lfpl_pkg::PDATA_W;
    localparam int OIDX_W   = lfpl_pkg::BULB_IDX_W;
    localparam int WSUM_W   = 10;
    localparam int WPROD_W  = WSUM_W + WEIGHT_W;

    // Configuration registers.
    lfpl_pkg::t_cfg    r_cfg;
    lfpl_pkg::t_reg    cfg_sel;
    logic              cfg_wr;

    assign pready  = 1'b1;
    assign cfg_sel = lfpl_pkg::t_reg'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cool_ratio   <= lfpl_pkg::RST_COOL_RATIO;
            r_cfg.warm_ratio   <= lfpl_pkg::RST_WARM_RATIO;
            r_cfg.white_gain   <= lfpl_pkg::RST_WHITE_GAIN;
            r_cfg.cool_tint    <= lfpl_pkg::RST_COOL_TINT;
            r_cfg.power_budget <= lfpl_pkg::RST_POWER_BUDGET;
            r_cfg.warm_channel <= lfpl_pkg::RST_WARM_CHANNEL;
            r_cfg.cool_channel <= lfpl_pkg::RST_COOL_CHANNEL;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                lfpl_pkg::REG_COOL_RATIO:   r_cfg.cool_ratio   <= pwdata[8:0];
                lfpl_pkg::REG_WARM_RATIO:   r_cfg.warm_ratio   <= pwdata[8:0];
                lfpl_pkg::REG_WHITE_GAIN:   r_cfg.white_gain   <= pwdata[9:0];
                lfpl_pkg::REG_COOL_TINT:    r_cfg.cool_tint    <= pwdata[26:0];
                lfpl_pkg::REG_POWER_BUDGET: r_cfg.power_budget <= pwdata[17:0];
                lfpl_pkg::REG_WARM_CHANNEL: r_cfg.warm_channel <= pwdata[1:0];
                lfpl_pkg::REG_COOL_CHANNEL: r_cfg.cool_channel <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            lfpl_pkg::REG_COOL_RATIO:   prdata = PDATA_W'(r_cfg.cool_ratio);
            lfpl_pkg::REG_WARM_RATIO:   prdata = PDATA_W'(r_cfg.warm_ratio);
            lfpl_pkg::REG_WHITE_GAIN:   prdata = PDATA_W'(r_cfg.white_gain);
            lfpl_pkg::REG_COOL_TINT:    prdata = PDATA_W'(r_cfg.cool_tint);
            lfpl_pkg::REG_POWER_BUDGET: prdata = PDATA_W'(r_cfg.power_budget);
            lfpl_pkg::REG_WARM_CHANNEL: prdata = PDATA_W'(r_cfg.warm_channel);
            lfpl_pkg::REG_COOL_CHANNEL: prdata = PDATA_W'(r_cfg.cool_channel);
            default:                    prdata = '0;
        endcase
    end

    // Sequencer state.
    lfpl_pkg::t_state  r_state;
    lfpl_pkg::t_state  n_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_issue_idx;
    logic [CNT_W-1:0]  r_acc_cnt;
    logic [IDX_W-1:0]  r_cur_idx;
    logic              r_inflight;
    logic [LOAD_W-1:0] r_load;
    logic              r_over;

    logic              in_acc;
    logic              store_wr;
    logic              rd_issue;
    logic              sum_done;
    logic              last_bulb;
    logic              res_valid;
    lfpl_pkg::t_pixel  res_px;
    lfpl_pkg::t_div_ctl div_ctl;
    logic              div_done;
    lfpl_pkg::t_pixel  div_quot;
    logic              out_take;

    assign in_acc    = i_valid && !o_stall;
    assign store_wr  = in_acc && (r_count < CNT_W'(MAX_BULBS));
    assign sum_done  = (r_acc_cnt == r_count);
    assign last_bulb = ((CNT_W'(r_cur_idx) + CNT_W'(1)) == r_count);
    assign out_take  = o_valid && !i_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lfpl_pkg::ST_LOAD: begin
                if (in_acc && i_frame_end) begin
                    n_state = lfpl_pkg::ST_SUM;
                end
            end
            lfpl_pkg::ST_SUM: begin
                if (sum_done) begin
                    n_state = lfpl_pkg::ST_EMIT;
                end
            end
            lfpl_pkg::ST_EMIT: begin
                if (div_ctl.take && last_bulb) begin
                    n_state = lfpl_pkg::ST_LOAD;
                end
            end
            default: n_state = lfpl_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        o_stall       = 1'b1;
        rd_issue      = 1'b0;
        div_ctl.start = 1'b0;
        div_ctl.take  = 1'b0;
        unique case (r_state)
            lfpl_pkg::ST_LOAD: begin
                o_stall = 1'b0;
            end
            lfpl_pkg::ST_SUM: begin
                rd_issue = (r_issue_idx < r_count);
            end
            lfpl_pkg::ST_EMIT: begin
                rd_issue      = !r_inflight && (r_issue_idx < r_count);
                div_ctl.start = res_valid;
                div_ctl.take  = div_done && (!o_valid || !i_stall);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfpl_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Bulb store: one write port for loading, one registered read port.
    logic [WORD_W-1:0] mem_store [MAX_BULBS];
    logic [WORD_W-1:0] r_word;
    logic              r_word_v;

    always_ff @(posedge i_clk) begin
        if (store_wr) begin
            mem_store[r_count[IDX_W-1:0]] <=
                {i_white_level, i_blue_level, i_green_level, i_red_level};
        end
        if (rd_issue) begin
            r_word <= mem_store[r_issue_idx[IDX_W-1:0]];
        end
    end

    lfpl_resolve u_resolve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_word_v),
        .i_word  (r_word),
        .i_cfg   (r_cfg),
        .o_valid (res_valid),
        .o_px    (res_px)
    );

    // Per-bulb load: RGB bytes plus the weighted white bytes.
    logic [WSUM_W-1:0]  wsum;
    logic [WPROD_W-1:0] wprod;
    logic [LOAD_W-1:0]  bulb_load;

    always_comb begin
        wsum      = WSUM_W'(res_px[3]) + WSUM_W'(res_px[4]) + WSUM_W'(res_px[5]);
        wprod     = WPROD_W'(wsum) * WPROD_W'(r_cfg.white_gain);
        bulb_load = LOAD_W'(res_px[0]) + LOAD_W'(res_px[1]) + LOAD_W'(res_px[2])
                  + LOAD_W'(wprod[WPROD_W-1:Q_SHIFT]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_issue_idx <= '0;
            r_acc_cnt   <= '0;
            r_inflight  <= 1'b0;
            r_load      <= '0;
            r_over      <= 1'b0;
            r_word_v    <= 1'b0;
        end else begin
            r_word_v <= rd_issue;
            if (store_wr) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (in_acc && i_frame_end) begin
                r_issue_idx <= '0;
                r_acc_cnt   <= '0;
                r_load      <= '0;
            end
            if (rd_issue) begin
                r_issue_idx <= r_issue_idx + CNT_W'(1);
            end
            if (r_state == lfpl_pkg::ST_SUM) begin
                if (res_valid) begin
                    r_load    <= r_load + bulb_load;
                    r_acc_cnt <= r_acc_cnt + CNT_W'(1);
                end
                if (sum_done) begin
                    r_issue_idx <= '0;
                    r_over      <= (r_load > r_cfg.power_budget);
                end
            end
            if (r_state == lfpl_pkg::ST_EMIT) begin
                if (rd_issue) begin
                    r_inflight <= 1'b1;
                end
                if (div_ctl.take) begin
                    r_inflight <= 1'b0;
                    if (last_bulb) begin
                        r_count <= '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_cur_idx <= r_issue_idx[IDX_W-1:0];
        end
    end

    // Without scaling the divider runs with a divisor of one.
    lfpl_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_px    (res_px),
        .i_num   (r_over ? r_cfg.power_budget : LOAD_W'(1)),
        .i_den   (r_over ? r_load : LOAD_W'(1)),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Output register.
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (div_ctl.take) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_ctl.take) begin
            o_bulb_index   <= OIDX_W'(r_cur_idx);
            o_color_red    <= div_quot[0];
            o_color_green  <= div_quot[1];
            o_color_blue   <= div_quot[2];
            o_white_first  <= div_quot[3];
            o_white_second <= div_quot[4];
            o_white_third  <= div_quot[5];
            o_over_budget  <= r_over;
            o_total_load   <= r_load;
            o_final_bulb   <= last_bulb;
        end
    end

    assign o_valid = r_out_valid;

endmodule
